// ----- design/assert_macros.svh -----
// Assertion macros shared by the parser RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define HMHP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HMHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define HMHP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/hmhp_pkg.sv -----
// Types, codes and method tables for the HTTP message head parser.
// No dependencies; imported by the front, queue, back and top-level files.
package hmhp_pkg;

  localparam int TOK_MAX   = 9;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;
  localparam int N_METHODS = 8;

  localparam logic [15:0] MAX_LINE_RESET = 16'd8000;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_MSG_OK = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_BAD_TOKEN = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_NON_ASCII = 3'd2;
  localparam logic [2:0] ERR_CR_NO_LF  = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  localparam logic [3:0] METHOD_RESPONSE = 4'd8;

  localparam logic [2:0] PH_TOKEN    = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_START_LF = 3'd2;
  localparam logic [2:0] PH_HDR      = 3'd3;
  localparam logic [2:0] PH_HDR_LF   = 3'd4;
  localparam logic [2:0] PH_BODY     = 3'd5;
  localparam logic [2:0] PH_SINK     = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef logic [7:0][7:0] name_t;

  localparam name_t METHOD_TXT [N_METHODS] = '{
    '{8'h00, "T", "C", "E", "N", "N", "O", "C"},
    '{8'h00, 8'h00, "E", "T", "E", "L", "E", "D"},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "T", "E", "G"},
    '{8'h00, 8'h00, 8'h00, 8'h00, "D", "A", "E", "H"},
    '{8'h00, "S", "N", "O", "I", "T", "P", "O"},
    '{8'h00, 8'h00, 8'h00, 8'h00, "T", "S", "O", "P"},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "T", "U", "P"},
    '{8'h00, 8'h00, 8'h00, "E", "C", "A", "R", "T"}
  };

  localparam logic [3:0] METHOD_LEN [N_METHODS] = '{
    4'd7, 4'd6, 4'd3, 4'd4, 4'd7, 4'd4, 4'd3, 4'd5
  };

  localparam name_t VERSION_TXT = '{"1", ".", "1", "/", "P", "T", "T", "H"};

  typedef logic [TOK_MAX-1:0][7:0] tok_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_space;
    logic       is_print;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_blank;
    logic       is_high;
  } hmhp_class_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } match_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  method_code;
    logic [15:0] line_start;
    logic [15:0] key_length;
    logic [15:0] value_start;
    logic [15:0] value_length;
    logic [15:0] body_start;
    logic [15:0] span_length;
    logic [2:0]  error_code;
    logic [15:0] error_position;
  } hmhp_result_t;

  typedef struct packed {
    logic       pop;
    logic       last;
    logic [2:0] phase;
  } back_status_t;

  function automatic match_t match_token(tok_t tok, logic [3:0] cnt);
    match_t res;
    logic   ok;
    res = '0;
    for (int k = 0; k < N_METHODS; k++) begin
      ok = (cnt == METHOD_LEN[k]);
      for (int j = 0; j < 8; j++) begin
        if (4'(j) < METHOD_LEN[k] && tok[j] != METHOD_TXT[k][j]) begin
          ok = 1'b0;
        end
      end
      if (ok && !res.hit) begin
        res.hit  = 1'b1;
        res.code = 4'(k);
      end
    end
    ok = (cnt >= 4'd8);
    for (int j = 0; j < 8; j++) begin
      if (tok[j] != VERSION_TXT[j]) begin
        ok = 1'b0;
      end
    end
    if (ok && !res.hit) begin
      res.hit  = 1'b1;
      res.code = METHOD_RESPONSE;
    end
    return res;
  endfunction

endpackage

// ----- design/hmhp_channels.sv -----
// Handshake channel interfaces of the parser: byte input, result output, config.
// Depends on nothing; used by the parser modules.
interface hmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hmhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  method_code;
  logic [15:0] line_start;
  logic [15:0] key_length;
  logic [15:0] value_start;
  logic [15:0] value_length;
  logic [15:0] body_start;
  logic [15:0] span_length;
  logic [2:0]  error_code;
  logic [15:0] error_position;
  modport source (output valid, output kind, output method_code, output line_start,
                  output key_length, output value_start, output value_length,
                  output body_start, output span_length, output error_code,
                  output error_position, input ready);
  modport sink (input valid, input kind, input method_code, input line_start,
                input key_length, input value_start, input value_length,
                input body_start, input span_length, input error_code,
                input error_position, output ready);
endinterface

interface hmhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_line_len;
  modport source (output valid, output max_line_len, input ready);
  modport sink (input valid, input max_line_len, output ready);
endinterface

// ----- design/hmhp_front.sv -----
// Front end: accepts bytes, classifies them and tags each with its offset.
// Depends on hmhp_pkg and hmhp_in_if.
module hmhp_front
  import hmhp_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  hmhp_in_if.sink                                   in_chan,
  input  logic                                      q_full,
  output logic                                      q_push,
  output logic [OFFSET_BITS+$bits(hmhp_class_t)-1:0] q_data
);

  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_nxt;
  hmhp_class_t            cls;
  logic [7:0]             b;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;
  assign b             = in_chan.data_byte;

  always_comb begin
    cls          = '0;
    cls.data     = b;
    cls.last     = in_chan.last_byte;
    cls.is_space = (b == CH_SPACE);
    cls.is_print = (b > CH_SPACE) && (b < CH_DEL);
    cls.is_cr    = (b == CH_CR);
    cls.is_lf    = (b == CH_LF);
    cls.is_colon = (b == CH_COLON);
    cls.is_blank = (b == CH_SPACE) || (b == CH_TAB);
    cls.is_high  = b[7];
  end

  assign q_data = {pos_r, cls};

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = in_chan.last_byte ? '0 : pos_r + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- design/hmhp_queue.sv -----
// Short FIFO between front and back end, push and pop in the same cycle.
// Depends on hmhp_pkg for depth constants.
module hmhp_queue
  import hmhp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic             full
);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    count_r;
  logic [Q_AW:0]    count_nxt;
  logic             do_pop;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (Q_AW+1)'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/hmhp_back.sv -----
// Back end: runs the line and header state machine and holds the result register.
// Depends on hmhp_pkg, hmhp_out_if and hmhp_cfg_if.
module hmhp_back
  import hmhp_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      q_valid,
  input  logic [OFFSET_BITS+$bits(hmhp_class_t)-1:0] q_data,
  output back_status_t                              status,
  hmhp_out_if.source                                out_chan,
  hmhp_cfg_if.sink                                  cfg_chan
);

  localparam int OB = OFFSET_BITS;
  localparam int CW = (OB > 16) ? OB : 16;

  hmhp_class_t   e;
  logic [OB-1:0] pos;
  logic [OB-1:0] pos_inc;
  logic [OB-1:0] idx;
  logic [OB-1:0] cr_idx;
  logic          over;
  logic          go;
  match_t        mt;

  logic [15:0]   max_len_r;
  logic [2:0]    phase_r, phase_nxt;
  tok_t          tok_r;
  logic          tok_we;
  logic [3:0]    tok_cnt_r, tok_cnt_nxt;
  logic [OB-1:0] line_start_r, line_start_nxt;
  logic          colon_r, colon_nxt;
  logic [OB-1:0] key_len_r, key_len_nxt;
  logic [OB-1:0] vstart_r, vstart_nxt;
  logic          skip_r, skip_nxt;
  logic [OB-1:0] body_r, body_nxt;
  logic [3:0]    method_r, method_nxt;

  logic          err;
  logic [2:0]    err_code;
  logic          res_v;
  hmhp_result_t  res;
  logic          out_valid_r;
  hmhp_result_t  out_r;

  assign {pos, e} = q_data;
  assign go       = q_valid && (!out_valid_r || out_chan.ready);
  assign pos_inc  = pos + OB'(1);
  assign idx      = pos - line_start_r;
  assign cr_idx   = pos - OB'(1) - line_start_r;
  assign over     = CW'(idx) > CW'(max_len_r);
  assign mt       = match_token(tok_r, tok_cnt_r);

  assign status.pop   = go;
  assign status.last  = e.last;
  assign status.phase = phase_r;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    tok_we         = 1'b0;
    tok_cnt_nxt    = tok_cnt_r;
    line_start_nxt = line_start_r;
    colon_nxt      = colon_r;
    key_len_nxt    = key_len_r;
    vstart_nxt     = vstart_r;
    skip_nxt       = skip_r;
    body_nxt       = body_r;
    method_nxt     = method_r;
    err            = 1'b0;
    err_code       = ERR_BAD_TOKEN;
    res_v          = 1'b0;
    res            = '0;

    unique case (phase_r)
      PH_TOKEN: begin
        if (e.is_space) begin
          if (!mt.hit) begin
            err      = 1'b1;
            err_code = ERR_UNKNOWN;
          end else begin
            method_nxt = mt.code;
            phase_nxt  = PH_START;
          end
        end else if (e.is_print) begin
          if (tok_cnt_r >= 4'(TOK_MAX)) begin
            err      = 1'b1;
            err_code = ERR_BAD_TOKEN;
          end else begin
            tok_we      = 1'b1;
            tok_cnt_nxt = tok_cnt_r + 4'd1;
          end
        end else begin
          err      = 1'b1;
          err_code = ERR_BAD_TOKEN;
        end
      end
      PH_START: begin
        if (e.is_high) begin
          err      = 1'b1;
          err_code = ERR_NON_ASCII;
        end else if (over) begin
          err      = 1'b1;
          err_code = ERR_TOO_LONG;
        end else if (e.is_cr) begin
          phase_nxt = PH_START_LF;
        end
      end
      PH_START_LF: begin
        if (e.is_high) begin
          err      = 1'b1;
          err_code = ERR_NON_ASCII;
        end else if (!e.is_lf) begin
          err      = 1'b1;
          err_code = ERR_CR_NO_LF;
        end else begin
          res_v           = 1'b1;
          res.kind        = KIND_START;
          res.method_code = method_r;
          res.span_length = 16'(cr_idx);
          phase_nxt       = PH_HDR;
          line_start_nxt  = pos_inc;
          colon_nxt       = 1'b0;
          key_len_nxt     = '0;
          vstart_nxt      = '0;
          skip_nxt        = 1'b0;
        end
      end
      PH_HDR: begin
        if (e.is_high) begin
          err      = 1'b1;
          err_code = ERR_NON_ASCII;
        end else if (over) begin
          err      = 1'b1;
          err_code = ERR_TOO_LONG;
        end else if (e.is_cr) begin
          phase_nxt = PH_HDR_LF;
        end else if (!colon_r) begin
          if (e.is_colon) begin
            colon_nxt   = 1'b1;
            key_len_nxt = idx;
            vstart_nxt  = pos_inc;
            skip_nxt    = 1'b1;
          end
        end else if (skip_r) begin
          if (e.is_blank) begin
            vstart_nxt = pos_inc;
          end else begin
            skip_nxt = 1'b0;
          end
        end
      end
      PH_HDR_LF: begin
        if (e.is_high) begin
          err      = 1'b1;
          err_code = ERR_NON_ASCII;
        end else if (!e.is_lf) begin
          err      = 1'b1;
          err_code = ERR_CR_NO_LF;
        end else if (cr_idx == '0) begin
          body_nxt  = pos_inc;
          phase_nxt = PH_BODY;
        end else begin
          if (colon_r && ({1'b0, cr_idx} > ({1'b0, key_len_r} + (OB+1)'(1)))) begin
            res_v            = 1'b1;
            res.kind         = KIND_HEADER;
            res.line_start   = 16'(line_start_r);
            res.key_length   = 16'(key_len_r);
            res.value_start  = 16'(vstart_r);
            res.value_length = 16'(pos - OB'(1) - vstart_r);
          end
          line_start_nxt = pos_inc;
          colon_nxt      = 1'b0;
          key_len_nxt    = '0;
          vstart_nxt     = '0;
          skip_nxt       = 1'b0;
          phase_nxt      = PH_HDR;
        end
      end
      default: begin
      end
    endcase

    if (err) begin
      res_v              = 1'b1;
      res                = '0;
      res.kind           = KIND_ERROR;
      res.error_code     = err_code;
      res.error_position = 16'(pos);
      phase_nxt          = PH_SINK;
    end else if (e.last) begin
      if (phase_nxt == PH_BODY) begin
        res_v           = 1'b1;
        res             = '0;
        res.kind        = KIND_MSG_OK;
        res.body_start  = 16'(body_nxt);
        res.span_length = 16'(pos_inc - body_nxt);
      end else if (phase_nxt != PH_SINK) begin
        res_v              = 1'b1;
        res                = '0;
        res.kind           = KIND_ERROR;
        res.error_code     = ERR_TRUNCATED;
        res.error_position = 16'(pos);
      end
    end

    if (e.last) begin
      phase_nxt      = PH_TOKEN;
      tok_cnt_nxt    = '0;
      line_start_nxt = '0;
      body_nxt       = '0;
      method_nxt     = '0;
      colon_nxt      = 1'b0;
      key_len_nxt    = '0;
      vstart_nxt     = '0;
      skip_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TOK_MAX; i++) begin
      if (go && tok_we && tok_cnt_r == 4'(i)) begin
        tok_r[i] <= e.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LINE_RESET;
      phase_r      <= PH_TOKEN;
      tok_cnt_r    <= '0;
      line_start_r <= '0;
      colon_r      <= 1'b0;
      key_len_r    <= '0;
      vstart_r     <= '0;
      skip_r       <= 1'b0;
      body_r       <= '0;
      method_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        max_len_r <= cfg_chan.max_line_len;
      end
      if (go) begin
        phase_r      <= phase_nxt;
        tok_cnt_r    <= tok_cnt_nxt;
        line_start_r <= line_start_nxt;
        colon_r      <= colon_nxt;
        key_len_r    <= key_len_nxt;
        vstart_r     <= vstart_nxt;
        skip_r       <= skip_nxt;
        body_r       <= body_nxt;
        method_r     <= method_nxt;
        out_valid_r  <= res_v;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = out_r.kind;
  assign out_chan.method_code    = out_r.method_code;
  assign out_chan.line_start     = out_r.line_start;
  assign out_chan.key_length     = out_r.key_length;
  assign out_chan.value_start    = out_r.value_start;
  assign out_chan.value_length   = out_r.value_length;
  assign out_chan.body_start     = out_r.body_start;
  assign out_chan.span_length    = out_r.span_length;
  assign out_chan.error_code     = out_r.error_code;
  assign out_chan.error_position = out_r.error_position;

endmodule

// ----- design/http_message_head_parser.sv -----
// Top level of the HTTP message head parser: front end, byte queue, back end.
// Depends on hmhp_pkg, hmhp_channels, hmhp_front, hmhp_queue, hmhp_back.
//
//   channel   direction  payload                                  transfer when
//   in_chan   in         data_byte, last_byte                     valid && ready
//   out_chan  out        kind .. error_position (10 fields)       valid && ready
//   cfg_chan  in         max_line_len                             valid && ready
//
// One byte per cycle sustained while out_chan takes results; a byte passes the
// queue and the result register. The back end's per-byte state update sets that rate.
// rst_n is synchronous, active low; the token store is not cleared.
// A stalled result holds the back end; the 4-entry queue then fills and
// in_chan.ready drops.
`include "assert_macros.svh"

module http_message_head_parser
  import hmhp_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  hmhp_in_if.sink    in_chan,
  hmhp_out_if.source out_chan,
  hmhp_cfg_if.sink   cfg_chan
);

  localparam int QW = OFFSET_BITS + $bits(hmhp_class_t);

  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_valid;
  logic [QW-1:0] q_head;
  back_status_t  status;

  hmhp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  hmhp_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (status.pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .full       (q_full)
  );

  hmhp_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_head),
    .status   (status),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  `HMHP_ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full), "push into a full queue")
  `HMHP_ASSERT_SAME(a_pop_valid, status.pop, q_valid, "pop from an empty queue")
  `HMHP_ASSERT_NEXT(a_last_resets, status.pop && status.last, status.phase == PH_TOKEN,
                    "last byte did not return to token phase")
  `HMHP_ASSERT_SAME(a_err_code, out_chan.valid && out_chan.kind == KIND_ERROR,
                    out_chan.error_code <= ERR_TRUNCATED, "error code out of range")

endmodule
